### sv/ftd_pkg.sv
// ftd_pkg: shared types and constants for the float-to-decimal-text core.
// Used by ftd_ctrl, ftd_datapath and float_to_decimal_text_core.
// No dependencies.
package ftd_pkg;

  // ASCII codes emitted by the block
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_DOT   = 7'd46;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // IEEE-754 single precision layout
  localparam int MANT_BITS = 23;
  localparam int EXP_BIAS  = 127;

  // Biased exponent thresholds
  localparam logic [7:0] EXP_HUGE = 8'(EXP_BIAS + 31);        // e >= 31 -> 0.0
  localparam logic [7:0] EXP_BIG  = 8'(EXP_BIAS + MANT_BITS); // e >= 23 -> integer only
  localparam logic [7:0] EXP_ONE  = 8'(EXP_BIAS);             // e >= 0
  localparam logic [7:0] EXP_TINY = 8'(EXP_BIAS - MANT_BITS); // e < -23 -> 0.0

  // Binary to BCD conversion
  localparam int BCD_DIGITS = 10;
  localparam logic [4:0] CONV_LAST_STEP = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } state_t;

  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } char_sel_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic      load;
    logic      step;
    logic      prep;
    logic      emit;
    char_sel_t sel;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic conv_last;
    logic neg;
    logic int_last;
    logic frac_last;
    logic slot_free;
  } status_t;

endpackage

### sv/ftd_ctrl.sv
// ftd_ctrl: sequencing state machine for the float-to-decimal-text core.
// Drives datapath commands from datapath status.
// Depends on ftd_pkg.
module ftd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ftd_pkg::status_t status,
  output ftd_pkg::cmd_t    cmd
);

  ftd_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ftd_pkg::ST_IDLE: begin
        if (in_valid) state_next = ftd_pkg::ST_CONV;
      end
      ftd_pkg::ST_CONV: begin
        if (status.conv_last) state_next = ftd_pkg::ST_PREP;
      end
      ftd_pkg::ST_PREP: begin
        state_next = status.neg ? ftd_pkg::ST_SIGN : ftd_pkg::ST_INT;
      end
      ftd_pkg::ST_SIGN: begin
        if (status.slot_free) state_next = ftd_pkg::ST_INT;
      end
      ftd_pkg::ST_INT: begin
        if (status.slot_free && status.int_last) state_next = ftd_pkg::ST_DOT;
      end
      ftd_pkg::ST_DOT: begin
        if (status.slot_free) state_next = ftd_pkg::ST_FRAC;
      end
      ftd_pkg::ST_FRAC: begin
        if (status.slot_free && status.frac_last) state_next = ftd_pkg::ST_IDLE;
      end
      default: begin
        state_next = ftd_pkg::ST_IDLE;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.step = 1'b0;
    cmd.prep = 1'b0;
    cmd.emit = 1'b0;
    cmd.sel  = ftd_pkg::SEL_DOT;
    case (state)
      ftd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ftd_pkg::ST_CONV: begin
        cmd.step = 1'b1;
      end
      ftd_pkg::ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ftd_pkg::ST_SIGN: begin
        cmd.emit = 1'b1;
        cmd.sel  = ftd_pkg::SEL_MINUS;
      end
      ftd_pkg::ST_INT: begin
        cmd.emit = 1'b1;
        cmd.sel  = ftd_pkg::SEL_INT;
      end
      ftd_pkg::ST_DOT: begin
        cmd.emit = 1'b1;
        cmd.sel  = ftd_pkg::SEL_DOT;
      end
      ftd_pkg::ST_FRAC: begin
        cmd.emit = 1'b1;
        cmd.sel  = ftd_pkg::SEL_FRAC;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/ftd_datapath.sv
// ftd_datapath: float decode, shift-add-3 BCD conversion, fraction digit
// generation and the character output register.
// Depends on ftd_pkg.
module ftd_datapath #(
  parameter int MAX_FRACTION_DIGITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  ftd_pkg::cmd_t    cmd,
  output ftd_pkg::status_t status,
  input  logic [31:0]      float_bits,
  input  logic [4:0]       fraction_digits,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       text_char,
  output logic             last_char
);

  localparam int IDX_W = (MAX_FRACTION_DIGITS > 1) ? $clog2(MAX_FRACTION_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam logic [4:0] MAX_CFG = 5'(MAX_FRACTION_DIGITS);

  // Decode of the incoming float
  logic [7:0]  e_raw;
  logic [23:0] mant;
  logic        is_zero;
  logic [2:0]  sh_big;
  logic [4:0]  sh_ip, sh_fp, sh_tiny;
  logic [31:0] ip_load;
  logic [23:0] fp_load;
  logic [CNT_W-1:0] maxd_load;

  // Working registers
  logic             neg;
  logic [31:0]      ip_bin;
  logic [3:0]       bcd_dig [ftd_pkg::BCD_DIGITS];
  logic [3:0]       bcd_adj [ftd_pkg::BCD_DIGITS];
  logic [23:0]      fp;
  logic [27:0]      fp_x10;
  logic [3:0]       frac_buf [MAX_FRACTION_DIGITS];
  logic [CNT_W-1:0] gen_cnt;
  logic [CNT_W-1:0] maxd;
  logic [IDX_W-1:0] last_nz;
  logic [IDX_W-1:0] frac_ptr;
  logic [3:0]       int_ptr;
  logic [3:0]       msd;
  logic [4:0]       step_cnt;
  logic             gen_active;
  logic             advance;
  logic [6:0]       char_next;

  assign e_raw   = float_bits[30:23];
  assign mant    = {1'b1, float_bits[22:0]};
  assign is_zero = (float_bits[30:0] == 31'd0);
  assign sh_big  = 3'(e_raw - ftd_pkg::EXP_BIG);
  assign sh_ip   = 5'(ftd_pkg::EXP_BIG - e_raw);
  assign sh_fp   = 5'(e_raw - (ftd_pkg::EXP_ONE - 8'd1));
  assign sh_tiny = 5'((ftd_pkg::EXP_ONE - 8'd1) - e_raw);

  // Split the significand into integer and 24-bit fraction parts
  always_comb begin
    ip_load = '0;
    fp_load = '0;
    if (is_zero || e_raw >= ftd_pkg::EXP_HUGE || e_raw < ftd_pkg::EXP_TINY) begin
      ip_load = '0;
    end else if (e_raw >= ftd_pkg::EXP_BIG) begin
      ip_load = {8'd0, mant} << sh_big;
    end else if (e_raw >= ftd_pkg::EXP_ONE) begin
      ip_load = {8'd0, mant >> sh_ip};
      fp_load = mant << sh_fp;
    end else begin
      fp_load = mant >> sh_tiny;
    end
  end

  // Clamp the digit count to 1..MAX
  always_comb begin
    if (fraction_digits == 5'd0) begin
      maxd_load = CNT_W'(1);
    end else if (fraction_digits > MAX_CFG) begin
      maxd_load = CNT_W'(MAX_FRACTION_DIGITS);
    end else begin
      maxd_load = CNT_W'(fraction_digits);
    end
  end

  // Add-3 correction per BCD digit
  always_comb begin
    for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_dig[i] >= 4'd5) ? 4'(bcd_dig[i] + 4'd3) : bcd_dig[i];
    end
  end

  // Most significant nonzero BCD digit (0 when all zero)
  always_comb begin
    msd = '0;
    for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++) begin
      if (bcd_dig[i] != 4'd0) msd = 4'(i);
    end
  end

  assign fp_x10     = 28'({fp, 3'b000}) + 28'({fp, 1'b0});
  assign gen_active = (gen_cnt < maxd);

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
      gen_cnt  <= '0;
      maxd     <= CNT_W'(1);
      last_nz  <= '0;
      frac_ptr <= '0;
      int_ptr  <= '0;
    end else begin
      if (cmd.load) begin
        step_cnt <= '0;
        gen_cnt  <= '0;
        maxd     <= maxd_load;
        last_nz  <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + 5'd1;
        if (gen_active) begin
          gen_cnt <= gen_cnt + CNT_W'(1);
          if (fp_x10[27:24] != 4'd0) last_nz <= gen_cnt[IDX_W-1:0];
        end
      end
      if (cmd.prep) begin
        int_ptr  <= msd;
        frac_ptr <= '0;
      end else if (advance && cmd.sel == ftd_pkg::SEL_INT) begin
        int_ptr <= int_ptr - 4'd1;
      end else if (advance && cmd.sel == ftd_pkg::SEL_FRAC) begin
        frac_ptr <= frac_ptr + IDX_W'(1);
      end
    end
  end

  // Payload: binary shift-in, BCD digits, fraction digits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg    <= float_bits[31] & ~is_zero;
      ip_bin <= ip_load;
      fp     <= fp_load;
      for (int i = 0; i < ftd_pkg::BCD_DIGITS; i++) begin
        bcd_dig[i] <= '0;
      end
    end else if (cmd.step) begin
      ip_bin     <= {ip_bin[30:0], 1'b0};
      bcd_dig[0] <= {bcd_adj[0][2:0], ip_bin[31]};
      for (int i = 1; i < ftd_pkg::BCD_DIGITS; i++) begin
        bcd_dig[i] <= {bcd_adj[i][2:0], bcd_adj[i-1][3]};
      end
      if (gen_active) begin
        frac_buf[gen_cnt[IDX_W-1:0]] <= fp_x10[27:24];
        fp <= fp_x10[23:0];
      end
    end
  end

  // Character select
  always_comb begin
    case (cmd.sel)
      ftd_pkg::SEL_MINUS: char_next = ftd_pkg::CHAR_MINUS;
      ftd_pkg::SEL_INT:   char_next = ftd_pkg::CHAR_ZERO + 7'(bcd_dig[int_ptr]);
      ftd_pkg::SEL_DOT:   char_next = ftd_pkg::CHAR_DOT;
      ftd_pkg::SEL_FRAC:  char_next = ftd_pkg::CHAR_ZERO + 7'(frac_buf[frac_ptr]);
      default:            char_next = ftd_pkg::CHAR_DOT;
    endcase
  end

  assign status.slot_free = ~out_valid | out_ready;
  assign status.conv_last = (step_cnt == ftd_pkg::CONV_LAST_STEP);
  assign status.neg       = neg;
  assign status.int_last  = (int_ptr == 4'd0);
  assign status.frac_last = (frac_ptr == last_nz);
  assign advance          = cmd.emit & status.slot_free;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      text_char <= char_next;
      last_char <= (cmd.sel == ftd_pkg::SEL_FRAC) && status.frac_last;
    end
  end

  // Checks
  a_gen_bound: assert property (@(posedge clk) disable iff (rst) gen_cnt <= maxd)
    else $error("fraction digit count ran past its limit");

  a_gen_done: assert property (@(posedge clk) disable iff (rst)
    cmd.step && status.conv_last |=> gen_cnt == maxd)
    else $error("fraction digits not finished by end of conversion");

  a_frac_ptr: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.sel == ftd_pkg::SEL_FRAC |-> frac_ptr <= last_nz)
    else $error("fraction read pointer past last kept digit");

  a_int_lead: assert property (@(posedge clk) disable iff (rst)
    cmd.prep |=> (int_ptr == 4'd0 || bcd_dig[int_ptr] != 4'd0))
    else $error("integer text would start with a zero digit");

endmodule

### sv/float_to_decimal_text_core.sv
// float_to_decimal_text_core: top level, single-precision float to ASCII text.
// Holds the digit-count register; instantiates ftd_ctrl and ftd_datapath.
// Depends on ftd_pkg.
//
// s_tdata carries one 32-bit float bit pattern per transaction. The core
// answers with 3 to 36 ASCII characters on m_tdata, one per transaction,
// m_tlast set on the last character of each number.
// cfg_data sets the number of fraction digits generated (1 to
// MAX_FRACTION_DIGITS; 0 acts as 1, larger acts as the maximum). Write it
// only while the core is idle. cfg_ready is always high.
// One number is in work at a time; s_tready is high only when idle.
// After the input transaction the integer part goes through shift-add-3 BCD
// conversion (fraction digits are generated in the same cycles), then the
// ST_PREP setup state; characters then follow, one per cycle while m_tready
// stays high. A new input transaction is taken only after the last character
// of a number has been registered; the BCD loop takes most of the time per
// number.
// rst clears the controller and output valid and sets the digit count to 6.
// When m_tready is low the character in the output register holds and
// the core waits; nothing is dropped.
module float_to_decimal_text_core #(
  parameter int MAX_FRACTION_DIGITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] float_bits
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] text_char, [7] zero
  output logic        m_tlast,   // last_char
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // fraction_digits
);

  localparam logic [4:0] FRAC_DIGITS_RESET = 5'd6;

  logic [4:0]       fraction_digits;
  logic [6:0]       text_char;
  ftd_pkg::cmd_t    cmd;
  ftd_pkg::status_t status;

  // Digit-count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_digits <= FRAC_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      fraction_digits <= cfg_data;
    end
  end

  ftd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ftd_datapath #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .float_bits      (s_tdata),
    .fraction_digits (fraction_digits),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .text_char       (text_char),
    .last_char       (m_tlast)
  );

  assign m_tdata = {1'b0, text_char};

endmodule
